FILE: hw/rtl/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Types and constants for the barometric compensation block.
// ----------------------------------------------------------------------------
package bsc_pkg;

	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 48;

	localparam logic [CfgIdxW-1:0] CFG_OSS    = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_AC123  = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_AC456  = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_B1B2   = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_MCMD   = 3'd4;

	localparam logic [31:0] K_4000  = 32'd4000;
	localparam logic [31:0] K_3038  = 32'd3038;
	localparam logic [31:0] K_M7357 = 32'hFFFF_E343;
	localparam logic [31:0] K_3791  = 32'd3791;
	localparam logic [31:0] K_32768 = 32'd32768;
	localparam logic [31:0] K_50000 = 32'd50000;
	localparam logic [31:0] K_SIGN  = 32'h8000_0000;

	typedef enum logic {KIND_TEMP = 1'b0, KIND_PRES = 1'b1} kind_t;

	typedef struct packed {
		logic        req_type;
		logic [23:0] raw_count;
	} in_beat_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] result_value;
		logic        div_error;
	} out_beat_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_T_X1,  ST_T_DEN, ST_T_DIV, ST_T_FIN,
		ST_P_SQ,  ST_P_X1A, ST_P_X2A, ST_P_B3,  ST_P_X1B, ST_P_X2B,
		ST_P_B4,  ST_P_B7,  ST_P_DIV, ST_P_Q,   ST_P_PP,  ST_P_X1C,
		ST_P_X2C, ST_P_FIN,
		ST_OUT
	} state_t;

	function automatic logic [31:0] sx16(input logic [15:0] v);
		return {{16{v[15]}}, v};
	endfunction

endpackage

FILE: hw/rtl/barometric_sensor_compensation.sv
// ----------------------------------------------------------------------------
// barometric_sensor_compensation
// Integer temperature and pressure compensation with one shared multiplier
// and a one-bit-a-cycle divider.
// ----------------------------------------------------------------------------
// Usage:
//  - in_valid/in_stall carry one beat: a temperature or a pressure reading.
//  - out_valid/out_stall return exactly one beat per input beat.
//  - cfg_we/cfg_idx/cfg_data write the oversampling and calibration words;
//    write only while the block is idle.
// Sequence:
//  - Temperature: two multiplier/setup steps, the restoring divider (32 steps
//    and the sign fix-up), one final step.
//  - Pressure: 8 multiplier/shift steps, the divider, then 5 more steps.
//  - Zero divisor: the divider is skipped and a div_error result follows
//    ST_T_DEN (temperature) or ST_P_B7 (pressure).
//  - in_stall is high while the sequencer is not idle: from accept until,
//    after the result beat is taken, ST_OUT returns to idle, so one item is
//    in flight at a time.
// Reset: all calibration, oversampling and the stored B5 clear to zero; the
//  sequencer returns to idle.
// Stall: a result waits in the output register unchanged while out_stall is
//  high; no further beat is accepted until it goes.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation
	import bsc_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  in_beat_t            in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output out_beat_t           out_data,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_idx,
	input  logic [CfgDataW-1:0] cfg_data
);

	// configuration
	logic [1:0]  oss_q;
	logic [47:0] ac123_q, ac456_q;
	logic [31:0] b1b2_q, mcmd_q;
	logic [31:0] b5_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oss_q   <= '0;
			ac123_q <= '0;
			ac456_q <= '0;
			b1b2_q  <= '0;
			mcmd_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_OSS:   oss_q   <= cfg_data[1:0];
				CFG_AC123: ac123_q <= cfg_data;
				CFG_AC456: ac456_q <= cfg_data;
				CFG_B1B2:  b1b2_q  <= cfg_data[31:0];
				CFG_MCMD:  mcmd_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	// calibration words
	logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
	assign ac1 = sx16(ac123_q[47:32]);
	assign ac2 = sx16(ac123_q[31:16]);
	assign ac3 = sx16(ac123_q[15:0]);
	assign ac4 = {16'd0, ac456_q[47:32]};
	assign ac5 = {16'd0, ac456_q[31:16]};
	assign ac6 = {16'd0, ac456_q[15:0]};
	assign b1  = sx16(b1b2_q[31:16]);
	assign b2  = sx16(b1b2_q[15:0]);
	assign mc  = sx16(mcmd_q[31:16]);
	assign md  = sx16(mcmd_q[15:0]);

	state_t state_q, state_d;
	logic [23:0] raw_q;
	logic [31:0] a_q, b6_q, sq_q, x1_q, b3_q, b7_q, p_q;
	logic [5:0]  cnt_q;
	// divider
	logic [31:0] dq_q, dr_q, dd_q;
	logic        dneg_q;
	out_beat_t   out_q;
	logic        ovalid_q;

	logic [31:0] sum_x, den_t, b4_v, b7_v, x3_v;
	assign sum_x = x1_q + a_q;

	// shared multiplier
	logic [31:0] mul_a, mul_b, mul_p;
	logic [63:0] mul_full;
	assign mul_full = mul_a * mul_b;
	assign mul_p    = mul_full[31:0];

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_T_X1:  begin mul_a = {16'd0, raw_q[15:0]} - ac6; mul_b = ac5; end
			ST_P_SQ:  begin mul_a = b6_q; mul_b = b6_q; end
			ST_P_X1A: begin mul_a = b2;   mul_b = sq_q; end
			ST_P_X2A: begin mul_a = ac2;  mul_b = b6_q; end
			ST_P_X1B: begin mul_a = ac3;  mul_b = b6_q; end
			ST_P_X2B: begin mul_a = b1;   mul_b = sq_q; end
			ST_P_B4:  begin mul_a = ac4;  mul_b = x3_v + K_32768; end
			ST_P_B7:  begin mul_a = ({8'd0, raw_q} >> (4'd8 - {2'd0, oss_q})) - b3_q;
				mul_b = K_50000 >> oss_q; end
			ST_P_PP:  begin mul_a = {{8{p_q[31]}}, p_q[31:8]};
				mul_b = {{8{p_q[31]}}, p_q[31:8]}; end
			ST_P_X1C: begin mul_a = x1_q; mul_b = K_3038; end
			ST_P_X2C: begin mul_a = K_M7357; mul_b = p_q; end
			default: ;
		endcase
	end

	logic done_div;
	assign done_div = (cnt_q == 6'd0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_d = in_data.req_type ? ST_P_SQ : ST_T_X1;
			ST_T_X1:  state_d = ST_T_DEN;
			ST_T_DEN: state_d = (x1_q + md == 32'd0) ? ST_OUT : ST_T_DIV;
			ST_T_DIV: if (done_div) state_d = ST_T_FIN;
			ST_T_FIN: state_d = ST_OUT;
			ST_P_SQ:  state_d = ST_P_X1A;
			ST_P_X1A: state_d = ST_P_X2A;
			ST_P_X2A: state_d = ST_P_B3;
			ST_P_B3:  state_d = ST_P_X1B;
			ST_P_X1B: state_d = ST_P_X2B;
			ST_P_X2B: state_d = ST_P_B4;
			ST_P_B4:  state_d = ST_P_B7;
			ST_P_B7:  state_d = (a_q == 32'd0) ? ST_OUT : ST_P_DIV;
			ST_P_DIV: if (done_div) state_d = ST_P_Q;
			ST_P_Q:   state_d = ST_P_PP;
			ST_P_PP:  state_d = ST_P_X1C;
			ST_P_X1C: state_d = ST_P_X2C;
			ST_P_X2C: state_d = ST_P_FIN;
			ST_P_FIN: state_d = ST_OUT;
			ST_OUT:   if (!ovalid_q) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

	// one restoring divider step
	logic [32:0] rem_sh;
	logic [32:0] rem_sub;
	assign rem_sh  = {dr_q, dq_q[31]};
	assign rem_sub = rem_sh - {1'b0, dd_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			ovalid_q <= 1'b0;
			b5_q     <= '0;
		end else begin
			state_q <= state_d;
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			if (state_q == ST_T_FIN) b5_q <= x1_q + dq_q;
			if (state_q != ST_OUT && state_d == ST_OUT) ovalid_q <= 1'b1;
		end
	end

	assign den_t = x1_q + md;
	assign b4_v  = {15'd0, mul_p[31:15]};
	assign b7_v  = mul_p;
	assign x3_v  = $signed(sum_x + 32'd2) >>> 2;

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				raw_q  <= in_data.raw_count;
				b6_q   <= b5_q - K_4000;
			end
			ST_T_X1: x1_q <= $signed(mul_p) >>> 15;
			ST_T_DEN: begin
				// |mc<<11| / |den|
				dq_q   <= mc[31] ? 32'd0 - (mc << 11) : (mc << 11);
				dd_q   <= den_t[31] ? 32'd0 - den_t : den_t;
				dneg_q <= mc[31] ^ den_t[31];
				dr_q   <= '0;
				cnt_q  <= 6'd32;
				if (den_t == 32'd0)
					out_q <= '{result_kind: KIND_TEMP, result_value: '0, div_error: 1'b1};
			end
			ST_T_DIV, ST_P_DIV: begin
				if (!done_div) begin
					if (!rem_sub[32]) begin
						dr_q <= rem_sub[31:0];
						dq_q <= {dq_q[30:0], 1'b1};
					end else begin
						dr_q <= rem_sh[31:0];
						dq_q <= {dq_q[30:0], 1'b0};
					end
					cnt_q <= cnt_q - 6'd1;
				end else if (state_q == ST_T_DIV && dneg_q) begin
					dq_q <= 32'd0 - dq_q;
				end
			end
			ST_T_FIN: out_q <= '{result_kind: KIND_TEMP,
				result_value: $signed(x1_q + dq_q + 32'd8) >>> 4, div_error: 1'b0};
			ST_P_SQ:  sq_q <= $signed(mul_p) >>> 12;
			ST_P_X1A: x1_q <= $signed(mul_p) >>> 11;
			ST_P_X2A: a_q  <= $signed(mul_p) >>> 11;
			ST_P_B3:  b3_q <= $signed((((ac1 << 2) + sum_x) << oss_q) + 32'd2) >>> 2;
			ST_P_X1B: x1_q <= $signed(mul_p) >>> 13;
			ST_P_X2B: a_q  <= $signed(mul_p) >>> 16;
			ST_P_B4:  a_q  <= b4_v;
			ST_P_B7: begin
				b7_q  <= b7_v;
				dq_q  <= (b7_v < K_SIGN) ? (b7_v << 1) : b7_v;
				dd_q  <= a_q;
				dr_q  <= '0;
				cnt_q <= 6'd32;
				if (a_q == 32'd0)
					out_q <= '{result_kind: KIND_PRES, result_value: '0, div_error: 1'b1};
			end
			ST_P_Q:   p_q  <= (b7_q < K_SIGN) ? dq_q : (dq_q << 1);
			ST_P_PP:  x1_q <= mul_p;
			ST_P_X1C: x1_q <= $signed(mul_p) >>> 16;
			ST_P_X2C: a_q  <= $signed(mul_p) >>> 16;
			ST_P_FIN: out_q <= '{result_kind: KIND_PRES,
				result_value: p_q + $unsigned($signed(sum_x + K_3791) >>> 4),
				div_error: 1'b0};
			default: ;
		endcase
	end

	assign out_valid = ovalid_q;
	assign out_data  = out_q;

`ifndef SYNTHESIS
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall) else $error("result while idle");
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> !out_valid) else $error("stale result");
	a_div_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_P_DIV || state_q == ST_T_DIV) |-> cnt_q <= 6'd32)
		else $error("divider count");
`endif

endmodule
